// ===== hw/rtl/mrwr_pkg.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness round package
// Shared constants, verdict codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none
package mrwr_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    REASON_TWO       = 2'd0,
    REASON_TRIVIAL   = 2'd1,
    REASON_PASSED    = 2'd2,
    REASON_COMPOSITE = 2'd3
  } reason_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_CHECK,
    ST_SQ,
    ST_SQ_CHECK,
    ST_DONE
  } state_t;

  // Start pulse and done flag of the shared modular multiplier.
  typedef struct packed {
    logic start;
  } mm_ctl_t;

  typedef struct packed {
    logic done;
  } mm_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/miller_rabin_witness_round.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness round
// One strong-probable-prime round for a candidate and one witness base.
// ----------------------------------------------------------------------------
// A candidate that is two, even or below two goes from idle straight to the
// done state. For an odd candidate the witness is first reduced by restoring
// division, then up to 2*WIDTH serial modular products follow on the
// bit-serial multiplier; one item is worked at a time. The result register
// frees the engine: a new beat is taken while the verdict waits.
// Synchronous active-low reset clears all control state.
`default_nettype none
module miller_rabin_witness_round
  import mrwr_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_candidate,
  input  wire logic [31:0] in_witness,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_probable_prime,
  output logic [1:0]       out_verdict_reason
);

  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam int unsigned IW = (WIDTH < 32) ? WIDTH : 32;

  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] n_r, n_nxt;       // candidate
  logic [WIDTH-1:0] w_r, w_nxt;       // witness, then reduced base
  logic [WIDTH:0]   rem_r, rem_nxt;   // restoring-division remainder
  logic [WIDTH-1:0] d_r, d_nxt;       // exponent, shifted right as used
  logic [CW-1:0]    s_r, s_nxt;       // trailing zero count, then squarings left plus one
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;       // accumulator of the power
  logic             pend_r, pend_nxt; // a product is in flight
  logic             ov_r, ov_nxt;
  logic             pp_r, pp_nxt;
  reason_t          rs_r, rs_nxt;

  mm_ctl_t          mm_ctl;
  mm_sts_t          mm_sts;
  logic [WIDTH-1:0] mm_a, mm_b, mm_p;

  mrwr_modmul #(.WIDTH(WIDTH)) u_mm (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mm_ctl),
    .a    (mm_a),
    .b    (mm_b),
    .m    (n_r),
    .sts  (mm_sts),
    .p    (mm_p)
  );

  logic [WIDTH-1:0] nm1;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH-1:0] cand_w, wit_w;

  assign nm1 = n_r - 1'b1;
  assign cand_w = WIDTH'(in_candidate[IW-1:0]);
  assign wit_w  = WIDTH'(in_witness[IW-1:0]);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    w_nxt      = w_r;
    rem_nxt    = rem_r;
    d_nxt      = d_r;
    s_nxt      = s_r;
    cnt_nxt    = cnt_r;
    x_nxt      = x_r;
    pend_nxt   = pend_r;
    pp_nxt     = pp_r;
    rs_nxt     = rs_r;
    ov_nxt     = ov_r;
    mm_ctl     = '0;
    mm_a       = x_r;
    mm_b       = w_r;
    rem_sh     = {rem_r[WIDTH-1:0], w_r[WIDTH-1]};
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          n_nxt = cand_w;
          w_nxt = wit_w;
          rem_nxt = '0;
          cnt_nxt = CW'(WIDTH);
          if (cand_w == WIDTH'(2)) begin
            pp_nxt = 1'b1; rs_nxt = REASON_TWO; state_nxt = ST_DONE;
          end else if (!cand_w[0] || cand_w == WIDTH'(1)) begin
            pp_nxt = 1'b0; rs_nxt = REASON_TRIVIAL; state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      // Restoring division, one witness bit per cycle; quotient is dropped.
      ST_REDUCE: begin
        rem_nxt = (rem_sh >= {1'b0, n_r}) ? rem_sh - {1'b0, n_r} : rem_sh;
        w_nxt   = {w_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_SPLIT;
          d_nxt = nm1;
          s_nxt = '0;
        end
      end
      // Strip trailing zeros of n-1, one per cycle.
      ST_SPLIT: begin
        w_nxt = rem_r[WIDTH-1:0];
        if (!d_r[0]) begin
          d_nxt = {1'b0, d_r[WIDTH-1:1]};
          s_nxt = s_r + 1'b1;
        end else begin
          x_nxt = WIDTH'(1);
          if (rem_r == '0) begin
            x_nxt = '0;
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_POW_MUL;
          end
        end
      end
      ST_POW_MUL: begin
        mm_a = x_r; mm_b = w_r;
        if (!d_r[0]) state_nxt = ST_POW_SQR;
        else if (!pend_r) begin
          mm_ctl.start = 1'b1; pend_nxt = 1'b1;
        end else if (mm_sts.done) begin
          x_nxt = mm_p; pend_nxt = 1'b0; state_nxt = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        mm_a = w_r; mm_b = w_r;
        if (!pend_r) begin
          mm_ctl.start = 1'b1; pend_nxt = 1'b1;
        end else if (mm_sts.done) begin
          w_nxt = mm_p; pend_nxt = 1'b0; state_nxt = ST_POW_NEXT;
        end
      end
      ST_POW_NEXT: begin
        d_nxt = {1'b0, d_r[WIDTH-1:1]};
        state_nxt = (d_r[WIDTH-1:1] == '0) ? ST_CHECK : ST_POW_MUL;
      end
      ST_CHECK: begin
        if (x_r == WIDTH'(1) || x_r == nm1) begin
          pp_nxt = 1'b1; rs_nxt = REASON_PASSED; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SQ_CHECK;
        end
      end
      ST_SQ: begin
        mm_a = x_r; mm_b = x_r;
        if (!pend_r) begin
          mm_ctl.start = 1'b1; pend_nxt = 1'b1;
        end else if (mm_sts.done) begin
          x_nxt = mm_p; pend_nxt = 1'b0;
          s_nxt = s_r - 1'b1;
          if (mm_p == WIDTH'(1)) begin
            pp_nxt = 1'b0; rs_nxt = REASON_COMPOSITE; state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SQ_CHECK;
          end
        end
      end
      // s_r counts squarings still allowed plus one.
      ST_SQ_CHECK: begin
        if (x_r == nm1) begin
          pp_nxt = 1'b1; rs_nxt = REASON_PASSED; state_nxt = ST_DONE;
        end else if (s_r <= CW'(1)) begin
          pp_nxt = 1'b0; rs_nxt = REASON_COMPOSITE; state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
    n_r   <= n_nxt;
    w_r   <= w_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    s_r   <= s_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    pp_r  <= pp_nxt;
    rs_r  <= rs_nxt;
  end

  // The output register holds one beat.
  logic       opp_r;
  logic [1:0] ors_r;
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!ov_r || out_ready)) begin
      opp_r <= pp_r;
      ors_r <= rs_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_probable_prime = opp_r;
  assign out_verdict_reason = ors_r;

  a_pass_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_probable_prime == (out_verdict_reason == REASON_TWO ||
                                         out_verdict_reason == REASON_PASSED))
    else $error("verdict and reason disagree");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("accept while busy");
  a_pend_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_POW_MUL || state_r == ST_POW_SQR || state_r == ST_SQ))
    else $error("product pending outside multiply");

endmodule
`default_nettype wire

// ===== hw/rtl/mrwr_modmul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes (a * b) mod m by add-and-double, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mrwr_modmul
  import mrwr_pkg::*;
#(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mm_ctl_t          ctl,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic [WIDTH-1:0] m,
  output mm_sts_t               sts,
  output logic [WIDTH-1:0]      p
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // (x + y) mod m for x, y < m; the extra bit catches the carry.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] md);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[WIDTH-1:0];
  endfunction

  logic [WIDTH-1:0] dbl;

  always_comb begin
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dbl      = add_mod(acc_r, acc_r, m);
    if (ctl.start) begin
      acc_nxt  = '0;
      b_nxt    = b;
      cnt_nxt  = CW'(WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = b_r[WIDTH-1] ? add_mod(dbl, a, m) : dbl;
      b_nxt   = {b_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
  end

  assign p        = acc_r;
  assign sts.done = done_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("multiplier done without work");
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("multiplier busy with zero count");
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && m != '0 |-> acc_r < m)
    else $error("product not reduced");

endmodule
`default_nettype wire

// ===== sim/miller_rabin_witness_round_test.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness round testbench
// Drives candidate and witness beats with random gaps and back-pressure,
// predicts each verdict with a local strong-probable-prime model and checks
// every result beat in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the verdicts still owed by the block, oldest first.
class verdict_board;
  logic         owed_prime[$];
  mrwr_pkg::reason_t owed_reason[$];
  int           errors;

  function void note_input(logic p, mrwr_pkg::reason_t r);
    owed_prime.push_back(p);
    owed_reason.push_back(r);
  endfunction

  // Prints one mismatch line and counts it.
  task report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(input logic p, input logic [1:0] r);
    logic              ep;
    mrwr_pkg::reason_t er;
    if (owed_prime.size() == 0) begin
      report($sformatf("result beat with no verdict owed (prime=%0b reason=%0d)", p, r));
      return;
    end
    ep = owed_prime.pop_front();
    er = owed_reason.pop_front();
    if (p !== ep)
      report($sformatf("probable_prime got %0b want %0b", p, ep));
    if (r !== er)
      report($sformatf("verdict_reason got %0d want %0d", r, er));
  endtask
endclass

module miller_rabin_witness_round_test
  import mrwr_pkg::*;
();

  localparam int LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_candidate;
  logic [31:0] in_witness;
  logic        out_valid;
  logic        out_ready;
  logic        out_probable_prime;
  logic [1:0]  out_verdict_reason;

  verdict_board board;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           cycles = 0;

  miller_rabin_witness_round DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_candidate(in_candidate), .in_witness(in_witness),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_probable_prime(out_probable_prime),
    .out_verdict_reason(out_verdict_reason)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Modular product by add-and-double; operands stay below m so 33 bits
  // suffice for every partial sum.
  function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b, logic [31:0] m);
    logic [32:0] acc;
    acc = '0;
    for (int k = 31; k >= 0; k--) begin
      acc = acc + acc;
      if (acc >= {1'b0, m}) acc = acc - m;
      if (b[k]) begin
        acc = acc + a;
        if (acc >= {1'b0, m}) acc = acc - m;
      end
    end
    return acc[31:0];
  endfunction

  // Works out the verdict of one witness round.
  task automatic predict_round(input logic [31:0] n, input logic [31:0] w,
                               output logic p, output reason_t r);
    logic [31:0] d, x, base, nm1;
    int          s;
    bit          ok;
    if (n == 32'd2) begin
      p = 1'b1; r = REASON_TWO; return;
    end
    if (n < 32'd2 || !n[0]) begin
      p = 1'b0; r = REASON_TRIVIAL; return;
    end
    nm1 = n - 1;
    d = nm1; s = 0;
    while (!d[0]) begin
      d = d >> 1; s++;
    end
    base = w % n;
    if (base == 0) x = 0;
    else begin
      x = 1;
      while (d != 0) begin
        if (d[0]) x = mulmod(x, base, n);
        base = mulmod(base, base, n);
        d = d >> 1;
      end
    end
    ok = 1;
    if (x != 1 && x != nm1) begin
      for (int i = 1; i < s && x != nm1; i++) begin
        x = mulmod(x, x, n);
        if (x == 1) begin
          ok = 0; break;
        end
      end
      if (x != nm1) ok = 0;
    end
    p = ok;
    r = ok ? REASON_PASSED : REASON_COMPOSITE;
  endtask

  // Sends one beat: random idle gap first, then hold valid until accepted.
  task automatic send_beat(input logic [31:0] n, input logic [31:0] w);
    logic    p;
    reason_t r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_candidate = n;
    in_witness   = w;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_round(n, w, p, r);
    board.note_input(p, r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random candidate; mostly small odd primes and composites, some full width of any parity.
  function automatic logic [31:0] rand_candidate();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return $urandom();
    if (sel < 6) return $urandom_range(65535) | 32'd1;
    return $urandom_range(4000) | 32'd1;
  endfunction

  // The receiver stalls at random; sampling happens on the rising edge.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_probable_prime, out_verdict_reason);
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("miller_rabin_witness_round_test: done, errors");
      $finish;
    end
  end

  // Directed special cases followed by three random phases of idling.
  initial begin
    logic [31:0] n;
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_candidate = '0;
    in_witness = '0;
    send_idle_pct = 28;
    recv_idle_pct = 53;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(32'd0, 32'd5);
    send_beat(32'd1, 32'hFFFFFFFF);
    send_beat(32'd2, 32'd0);
    send_beat(32'd4, 32'd3);
    send_beat(32'hFFFFFFFE, 32'd7);
    send_beat(32'd3, 32'd0);
    send_beat(32'd3, 32'd1);
    send_beat(32'd3, 32'd2);
    send_beat(32'd3, 32'hFFFFFFFF);
    send_beat(32'd97, 32'd97);
    send_beat(32'd97, 32'd1);
    send_beat(32'd97, 32'd96);
    send_beat(32'd561, 32'd2);
    send_beat(32'd2047, 32'd2);
    send_beat(32'd25, 32'd7);
    send_beat(32'hFFFFFFFB, 32'd2);
    send_beat(32'hFFFFFFFF, 32'hFFFFFFFE);
    send_beat(32'h7FFFFFFF, 32'hAAAAAAAA);
    send_beat(32'h80000001, 32'h55555555);
    send_beat(32'd65537, 32'd3);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 28 : 0;
      for (int k = 0; k < 84; k++) begin
        if ($urandom_range(9) == 0) send_beat($urandom(), $urandom());
        else begin
          n = rand_candidate();
          send_beat(n, ($urandom_range(7) == 0) ? n - 1 : $urandom());
        end
      end
    end

    while (board.owed_prime.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("miller_rabin_witness_round_test: done, clean");
    else
      $display("miller_rabin_witness_round_test: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
